[rtl/core/wbsm_pkg.sv]
`default_nettype none

package wbsm_pkg;

    // Default configuration of the matcher.
    localparam int ALPHABET_DEF = 5;
    localparam int MAX_WORD_DEF = 4;

    // Fixed port widths.
    localparam int REQ_W    = 1;
    localparam int LEN_W    = 3;
    localparam int CODE_W   = 10;
    localparam int SYMBOL_W = 3;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_INSERT = 1'b0;
    localparam logic [REQ_W-1:0] REQ_SYMBOL = 1'b1;

    // Integer power, used only at elaboration.
    function automatic longint pow_int(input int base, input int expo);
        longint p;
        p = 1;
        for (int k = 0; k < expo; k++) begin
            p = p * base;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/core/wbsm_ram.sv]
`default_nettype none

module wbsm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/word_break_stream_matcher_top.sv]
`default_nettype none

// Streaming word-break matcher. Insert transfers add words of length 1 to MAX_WORD to a
// dictionary held in one bit RAM per word length; symbol transfers extend the current window,
// and the symbol marked last returns whether the whole window splits into dictionary words.
// One transfer is accepted per cycle while o_stall is low; o_valid rises after the last symbol
// is accepted (the accepting edge loads the registered RAM lookups of all suffix lengths in
// parallel, then the result register loads from them). The only back-pressure in operation
// comes when a window ends while the previous result is still stalled at the output. After
// reset the dictionary RAMs are cleared in parallel, one address per cycle, covering
// ALPHABET**MAX_WORD addresses (625 for the default configuration); no transfer is accepted
// during that pass.
module word_break_stream_matcher_top
    import wbsm_pkg::*;
#(
    parameter int ALPHABET = ALPHABET_DEF,
    parameter int MAX_WORD = MAX_WORD_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic [LEN_W-1:0]    i_word_len,
    input  wire logic [CODE_W-1:0]   i_word_code,
    input  wire logic [SYMBOL_W-1:0] i_symbol,
    input  wire logic                i_last_symbol,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_breakable
);

    localparam longint DEPTH_MAX = pow_int(ALPHABET, MAX_WORD);
    localparam int     CW        = $clog2(DEPTH_MAX);
    localparam int     MW        = CW + 5;

    // Clearing pass.
    logic                r_clr_active;
    logic [CW-1:0]       r_clr_addr;

    // Suffix codes of the last 1..MAX_WORD symbols, newest symbol least significant.
    logic [CW-1:0]       r_code [MAX_WORD];
    logic [MAX_WORD-1:0] r_ok;
    logic [CW-1:0]       n_code [MAX_WORD];
    logic [MAX_WORD-1:0] n_ok;

    // Lookup stage.
    logic                r_s1_valid;
    logic                r_s1_last;
    logic [MAX_WORD-1:0] r_s1_ok;
    logic [MAX_WORD-1:0] r_reach;
    logic [MAX_WORD-1:0] w_rd;

    logic                r_out_valid;
    logic                r_out_breakable;

    logic                w_blocked;
    logic                w_accept;
    logic                w_acc_sym;
    logic                w_acc_ins;
    logic                w_sym_ok;
    logic                w_hit;

    assign w_blocked = r_s1_valid && r_s1_last && r_out_valid && i_stall;
    assign o_stall   = r_clr_active || w_blocked;
    assign w_accept  = i_valid && !o_stall;
    assign w_acc_sym = w_accept && (i_req_type == REQ_SYMBOL);
    assign w_acc_ins = w_accept && (i_req_type == REQ_INSERT);
    assign w_sym_ok  = 32'(i_symbol) < ALPHABET;

    for (genvar l = 0; l < MAX_WORD; l++) begin : g_lane
        localparam longint LANE_DEPTH = pow_int(ALPHABET, l + 1);
        localparam int     AW         = $clog2(LANE_DEPTH);

        logic [MW-1:0] prev_code;
        logic [MW-1:0] sum;
        logic          prev_ok;
        logic          we;
        logic [AW-1:0] waddr;
        logic          wdata;

        if (l == 0) begin : g_first
            assign prev_code = '0;
            assign prev_ok   = 1'b1;
        end else begin : g_rest
            assign prev_code = MW'(r_code[l-1]);
            assign prev_ok   = r_ok[l-1];
        end

        // Appending the new symbol at the low end shifts the older digits up one place.
        assign sum       = prev_code * MW'(ALPHABET) + MW'(i_symbol);
        assign n_code[l] = sum[CW-1:0];
        assign n_ok[l]   = w_sym_ok && prev_ok;

        always_comb begin
            if (r_clr_active) begin
                we    = 64'(r_clr_addr) < LANE_DEPTH;
                waddr = AW'(r_clr_addr);
                wdata = 1'b0;
            end else begin
                we    = w_acc_ins && (i_word_len == LEN_W'(l + 1))
                        && (64'(i_word_code) < LANE_DEPTH);
                waddr = AW'(i_word_code);
                wdata = 1'b1;
            end
        end

        wbsm_ram #(
            .WIDTH (1),
            .DEPTH (int'(LANE_DEPTH))
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (w_acc_sym),
            .i_raddr (AW'(n_code[l])),
            .o_rdata (w_rd[l])
        );
    end

    assign w_hit = |(r_s1_ok & r_reach & w_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_ok         <= '1;
            r_s1_valid   <= 1'b0;
            r_reach      <= MAX_WORD'(1);
            r_out_valid  <= 1'b0;
            for (int k = 0; k < MAX_WORD; k++) begin
                r_code[k] <= '0;
            end
        end else begin
            if (r_clr_active) begin
                if (r_clr_addr == CW'(DEPTH_MAX - 1)) begin
                    r_clr_active <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end

            // A window end restarts the symbol history.
            if (w_acc_sym) begin
                if (i_last_symbol) begin
                    r_ok <= '1;
                    for (int k = 0; k < MAX_WORD; k++) begin
                        r_code[k] <= '0;
                    end
                end else begin
                    r_ok <= n_ok;
                    for (int k = 0; k < MAX_WORD; k++) begin
                        r_code[k] <= n_code[k];
                    end
                end
            end

            if (!w_blocked) begin
                r_s1_valid <= w_acc_sym;
                if (r_s1_valid) begin
                    if (r_s1_last) begin
                        r_reach <= MAX_WORD'(1);
                    end else begin
                        r_reach <= MAX_WORD'({r_reach, w_hit});
                    end
                end
            end

            if (r_s1_valid && r_s1_last && !w_blocked) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_blocked) begin
            r_s1_last <= i_last_symbol;
            r_s1_ok   <= n_ok;
        end
        if (r_s1_valid && r_s1_last && !w_blocked) begin
            r_out_breakable <= w_hit;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_breakable = r_out_breakable;

`ifndef SYNTHESIS
    a_result_from_window_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("result appeared without a window end in the lookup stage");

    a_reach_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && !w_blocked) |=> (r_reach == MAX_WORD'(1)))
        else $error("reachability not restarted after a window end");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_blocked |=> (r_s1_valid && r_s1_last))
        else $error("lookup stage lost a window end while blocked");

    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_active) |-> ($past(r_clr_addr) == CW'(DEPTH_MAX - 1)))
        else $error("clearing pass ended early");

    a_no_lookup_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |=> !r_s1_valid)
        else $error("symbol lookup issued during clearing pass");
`endif

endmodule

`default_nettype wire
